// ===== rtl/core/linear_alpha_gradient_mask_macros.svh =====
// ----------------------------------------------------------------------------
// Linear alpha gradient mask assertion macros
// Property forms for the lagm_checker of the gradient mask. The names clk
// and rst_n must be visible where a macro is used.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ALPHA_GRADIENT_MASK_MACROS_SVH
`define LINEAR_ALPHA_GRADIENT_MASK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAGM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAGM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lagm_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear alpha gradient mask package
// Field widths, fixed-point constants and register indexes shared by the
// gradient mask, its checkers and testbench, and the mask's sine table generator.
// ----------------------------------------------------------------------------
package lagm_pkg;

    localparam int LAGM_POS_W      = 12;
    localparam int LAGM_ALPHA_W    = 8;
    localparam int LAGM_CENTER_W   = 17;
    localparam int LAGM_SLOPE_W    = 24;
    localparam int LAGM_GAIN_W     = 17;
    localparam int LAGM_CFG_IDX_W  = 3;
    localparam int LAGM_CFG_DATA_W = 24;

    localparam int LAGM_SINE_DEPTH = 256;

    localparam int LAGM_HALF_Q24 = 8388608;
    localparam int LAGM_ONE_Q24  = 16777216;
    localparam int LAGM_ROUND_IDX = 4194304;

    localparam longint LAGM_HALF_PI_Q28 = 64'sd421657428;
    localparam int     LAGM_SINE_TERMS  = 12;
    localparam longint LAGM_SINE_DIV [LAGM_SINE_TERMS] =
        '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600};

    localparam logic [LAGM_GAIN_W-1:0]  LAGM_START_GAIN_RST = 17'd65536;
    localparam logic [LAGM_ALPHA_W-1:0] LAGM_ALPHA_MAX      = 8'hFF;
    localparam logic                    LAGM_SHAPE_SINE     = 1'b1;

    localparam logic [LAGM_CFG_IDX_W-1:0] LAGM_REG_CENTER_X   = 3'd0;
    localparam logic [LAGM_CFG_IDX_W-1:0] LAGM_REG_CENTER_Y   = 3'd1;
    localparam logic [LAGM_CFG_IDX_W-1:0] LAGM_REG_SLOPE_X    = 3'd2;
    localparam logic [LAGM_CFG_IDX_W-1:0] LAGM_REG_SLOPE_Y    = 3'd3;
    localparam logic [LAGM_CFG_IDX_W-1:0] LAGM_REG_START_GAIN = 3'd4;
    localparam logic [LAGM_CFG_IDX_W-1:0] LAGM_REG_END_GAIN   = 3'd5;
    localparam logic [LAGM_CFG_IDX_W-1:0] LAGM_REG_SHAPE_MODE = 3'd6;

    // Sine of a Q28 angle in Q16, by a truncated Taylor series in Q28.
    function automatic logic [LAGM_GAIN_W-1:0] lagm_sine_entry(input longint angle);
        longint x2;
        longint term;
        longint sum;
        x2   = (angle * angle) >>> 28;
        term = angle;
        sum  = angle;
        for (int k = 1; k <= LAGM_SINE_TERMS; k++)
        begin
            term = (term * x2) >>> 28;
            term = term / LAGM_SINE_DIV[k-1];
            if ((k % 2) == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        sum = (sum + 2048) >>> 12;
        if (sum > 65536)
        begin
            sum = 65536;
        end
        return sum[LAGM_GAIN_W-1:0];
    endfunction

endpackage

// ===== rtl/core/linear_alpha_gradient_mask.sv =====
// ----------------------------------------------------------------------------
// Linear alpha gradient mask
// Throughput: one item per clock while out_ready is high; every stage holds
// one item and bubbles close up under output backpressure. The sine table is
// a ROM read in stage 4. Reset clears all valid bits and loads the register
// defaults asynchronously.
// ----------------------------------------------------------------------------
module linear_alpha_gradient_mask
    import lagm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = LAGM_SINE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [LAGM_CFG_IDX_W-1:0]   cfg_index,
    input  logic [LAGM_CFG_DATA_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [LAGM_POS_W-1:0]       pixel_x,
    input  logic [LAGM_POS_W-1:0]       pixel_y,
    input  logic [LAGM_ALPHA_W-1:0]     alpha_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [LAGM_ALPHA_W-1:0]     alpha_out
);

    localparam int NStages = 9;
    localparam int IdxW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int MulW    = 25 + $clog2(SINE_TABLE_DEPTH);

    // Configuration registers.
    logic signed [LAGM_CENTER_W-1:0] center_x_reg;
    logic signed [LAGM_CENTER_W-1:0] center_y_reg;
    logic signed [LAGM_SLOPE_W-1:0]  slope_x_reg;
    logic signed [LAGM_SLOPE_W-1:0]  slope_y_reg;
    logic [LAGM_GAIN_W-1:0]          start_gain_reg;
    logic [LAGM_GAIN_W-1:0]          end_gain_reg;
    logic                            shape_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            slope_x_reg    <= '0;
            slope_y_reg    <= '0;
            start_gain_reg <= LAGM_START_GAIN_RST;
            end_gain_reg   <= '0;
            shape_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                LAGM_REG_CENTER_X:   center_x_reg   <= cfg_data[LAGM_CENTER_W-1:0];
                LAGM_REG_CENTER_Y:   center_y_reg   <= cfg_data[LAGM_CENTER_W-1:0];
                LAGM_REG_SLOPE_X:    slope_x_reg    <= cfg_data[LAGM_SLOPE_W-1:0];
                LAGM_REG_SLOPE_Y:    slope_y_reg    <= cfg_data[LAGM_SLOPE_W-1:0];
                LAGM_REG_START_GAIN: start_gain_reg <= cfg_data[LAGM_GAIN_W-1:0];
                LAGM_REG_END_GAIN:   end_gain_reg   <= cfg_data[LAGM_GAIN_W-1:0];
                LAGM_REG_SHAPE_MODE: shape_mode_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Quarter-wave sine ROM, built at elaboration.
    logic [LAGM_GAIN_W-1:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_sine_rom
        localparam longint SineAngle = (LAGM_HALF_PI_Q28 * g) / SINE_TABLE_DEPTH;
        assign sine_rom[g] = lagm_sine_entry(SineAngle);
    end

    // Pipeline control: a stage loads when it is empty or its item moves on.
    logic [NStages-1:0] vld_reg;
    logic [NStages-1:0] vld_next;
    logic [NStages:0]   stage_en;

    always_comb
    begin
        stage_en[NStages] = out_ready;
        for (int k = NStages - 1; k >= 0; k--)
        begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
        for (int k = 0; k < NStages; k++)
        begin
            if (!stage_en[k])
            begin
                vld_next[k] = vld_reg[k];
            end
            else if (k == 0)
            begin
                vld_next[k] = in_valid;
            end
            else
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = vld_reg[NStages-1];

    // Stage 0: offsets from the center in sixteenths of a pixel.
    logic signed [18:0]        dx_reg, dx_next;
    logic signed [18:0]        dy_reg, dy_next;
    logic [LAGM_ALPHA_W-1:0]   a0_reg;

    assign dx_next = $signed({3'b000, pixel_x, 4'b0000}) - 19'(center_x_reg);
    assign dy_next = $signed({3'b000, pixel_y, 4'b0000}) - 19'(center_y_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            a0_reg <= alpha_in;
        end
    end

    // Stage 1: projections onto the gradient axis.
    logic signed [42:0]        prx_reg, prx_next;
    logic signed [42:0]        pry_reg, pry_next;
    logic [LAGM_ALPHA_W-1:0]   a1_reg;

    assign prx_next = 43'(dx_reg) * 43'(slope_x_reg);
    assign pry_next = 43'(dy_reg) * 43'(slope_y_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            prx_reg <= prx_next;
            pry_reg <= pry_next;
            a1_reg  <= a0_reg;
        end
    end

    // Stage 2: projected distance in Q24.
    logic signed [43:0]        d_reg, d_next;
    logic [LAGM_ALPHA_W-1:0]   a2_reg;

    assign d_next = 44'(prx_reg) + 44'(pry_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            d_reg  <= d_next;
            a2_reg <= a1_reg;
        end
    end

    // Stage 3: band limits and the nearest sine table index.
    logic                      below_next, above_next, neg_next;
    logic signed [43:0]        d_abs;
    logic [23:0]               mag;
    logic [MulW-1:0]           idx_prod;
    logic [IdxW-1:0]           idx_next;
    logic                      below3_reg, above3_reg, neg3_reg;
    logic [IdxW-1:0]           idx_reg;
    logic [24:0]               dlin3_reg;
    logic [LAGM_ALPHA_W-1:0]   a3_reg;

    always_comb
    begin
        below_next = d_reg < -44'(LAGM_HALF_Q24);
        above_next = d_reg > 44'(LAGM_HALF_Q24);
        neg_next   = d_reg[43];
        d_abs      = neg_next ? -d_reg : d_reg;
        mag        = (below_next || above_next) ? '0 : d_abs[23:0];
        idx_prod   = MulW'(mag) * MulW'(SINE_TABLE_DEPTH) + MulW'(LAGM_ROUND_IDX);
        idx_next   = idx_prod[23 +: IdxW];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            below3_reg <= below_next;
            above3_reg <= above_next;
            neg3_reg   <= neg_next;
            idx_reg    <= idx_next;
            dlin3_reg  <= d_reg[24:0];
            a3_reg     <= a2_reg;
        end
    end

    // Stage 4: sine ROM read.
    logic [LAGM_GAIN_W-1:0]    sine_reg;
    logic                      below4_reg, above4_reg, neg4_reg;
    logic [24:0]               dlin4_reg;
    logic [LAGM_ALPHA_W-1:0]   a4_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            sine_reg   <= sine_rom[idx_reg];
            below4_reg <= below3_reg;
            above4_reg <= above3_reg;
            neg4_reg   <= neg3_reg;
            dlin4_reg  <= dlin3_reg;
            a4_reg     <= a3_reg;
        end
    end

    // Stage 5: interpolation position t in Q24, from 0 to one.
    logic [23:0]               sine_q24;
    logic [24:0]               t_next;
    logic [24:0]               t_reg;
    logic                      below5_reg, above5_reg;
    logic [LAGM_ALPHA_W-1:0]   a5_reg;

    always_comb
    begin
        sine_q24 = {sine_reg, 7'b0000000};
        if (shape_mode_reg == LAGM_SHAPE_SINE)
        begin
            t_next = neg4_reg ? 25'(LAGM_HALF_Q24) - 25'(sine_q24)
                              : 25'(LAGM_HALF_Q24) + 25'(sine_q24);
        end
        else
        begin
            t_next = dlin4_reg + 25'(LAGM_HALF_Q24);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            t_reg      <= t_next;
            below5_reg <= below4_reg;
            above5_reg <= above4_reg;
            a5_reg     <= a4_reg;
        end
    end

    // Stage 6: weighted gains.
    logic [41:0]               ws_reg, ws_next;
    logic [41:0]               we_reg, we_next;
    logic                      below6_reg, above6_reg;
    logic [LAGM_ALPHA_W-1:0]   a6_reg;

    assign ws_next = 42'(start_gain_reg) * 42'(25'(LAGM_ONE_Q24) - t_reg);
    assign we_next = 42'(end_gain_reg) * 42'(t_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            ws_reg     <= ws_next;
            we_reg     <= we_next;
            below6_reg <= below5_reg;
            above6_reg <= above5_reg;
            a6_reg     <= a5_reg;
        end
    end

    // Stage 7: gain selection.
    logic [42:0]               wsum;
    logic [LAGM_GAIN_W-1:0]    gain_reg, gain_next;
    logic [LAGM_ALPHA_W-1:0]   a7_reg;

    always_comb
    begin
        wsum = 43'(ws_reg) + 43'(we_reg);
        if (below6_reg)
        begin
            gain_next = start_gain_reg;
        end
        else if (above6_reg)
        begin
            gain_next = end_gain_reg;
        end
        else
        begin
            gain_next = wsum[24 +: LAGM_GAIN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            gain_reg <= gain_next;
            a7_reg   <= a6_reg;
        end
    end

    // Stage 8: scaled alpha with saturation, held until taken.
    logic [24:0]               scaled;
    logic [LAGM_ALPHA_W-1:0]   alpha_reg, alpha_next;

    always_comb
    begin
        scaled     = 25'(a7_reg) * 25'(gain_reg);
        alpha_next = scaled[24] ? LAGM_ALPHA_MAX : scaled[23:16];
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[8])
        begin
            alpha_reg <= alpha_next;
        end
    end

    assign alpha_out = alpha_reg;

endmodule

// ===== rtl/core/lagm_checker.sv =====
// ----------------------------------------------------------------------------
// Linear alpha gradient mask checker
// Watches the ports of the gradient mask for flow control and reset behavior.
// ----------------------------------------------------------------------------
`include "linear_alpha_gradient_mask_macros.svh"

module lagm_checker
    import lagm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [LAGM_ALPHA_W-1:0]     alpha_out
);

    // A waiting item keeps its value until it is taken.
    `LAGM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(alpha_out), "stalled item changed")

    // With the output free the whole pipeline moves, so input is taken.
    `LAGM_ASSERT_SAME(a_ready_when_free, !out_valid || out_ready, in_ready, "input stalled while output free")

    // No item can reach the output sooner than the pipeline depth after reset.
    `LAGM_ASSERT_SAME(a_reset_flush, $past(!rst_n, 8), !out_valid, "item appeared too soon after reset")

endmodule

bind linear_alpha_gradient_mask lagm_checker u_lagm_checker (.*);

// ===== test/lagm_alpha_checker.sv =====
// ----------------------------------------------------------------------------
// Gradient mask alpha checker
// Watches the configuration port and both item channels of the gradient mask.
// It keeps its own copy of the registers, predicts alpha_out for every
// accepted pixel, and compares each accepted result with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lagm_alpha_checker
    import lagm_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [LAGM_CFG_IDX_W-1:0]   cfg_index,
    input  logic [LAGM_CFG_DATA_W-1:0]  cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [LAGM_POS_W-1:0]       pixel_x,
    input  logic [LAGM_POS_W-1:0]       pixel_y,
    input  logic [LAGM_ALPHA_W-1:0]     alpha_in,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [LAGM_ALPHA_W-1:0]     alpha_out,
    output int                          mismatch_count,
    output int                          outstanding,
    output int                          checked
);

    typedef struct packed {
        logic [LAGM_POS_W-1:0]   px;
        logic [LAGM_POS_W-1:0]   py;
        logic [LAGM_ALPHA_W-1:0] alpha_src;
        logic [LAGM_ALPHA_W-1:0] alpha_exp;
    } masked_pixel_t;

    logic signed [LAGM_CENTER_W-1:0] center_x_q;
    logic signed [LAGM_CENTER_W-1:0] center_y_q;
    logic signed [LAGM_SLOPE_W-1:0]  slope_x_q;
    logic signed [LAGM_SLOPE_W-1:0]  slope_y_q;
    logic [LAGM_GAIN_W-1:0]          start_gain_q;
    logic [LAGM_GAIN_W-1:0]          end_gain_q;
    logic                            shape_q;

    longint        sine_q16 [0:LAGM_SINE_DEPTH];
    masked_pixel_t alpha_q [$];
    masked_pixel_t fresh_item;
    masked_pixel_t head_item;
    int            errors = 0;
    int            seen = 0;

    function automatic longint quarter_sine_q16(input int step);
        longint angle;
        longint angle_sq;
        longint term;
        longint acc;
        angle    = (LAGM_HALF_PI_Q28 * step) / LAGM_SINE_DEPTH;
        angle_sq = (angle * angle) >>> 28;
        term     = angle;
        acc      = angle;
        for (int k = 1; k <= 12; k++)
        begin
            term = (term * angle_sq) >>> 28;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        acc = (acc + 2048) >>> 12;
        if (acc > 65536)
        begin
            acc = 65536;
        end
        return acc;
    endfunction

    function automatic logic [LAGM_ALPHA_W-1:0] gradient_alpha(
        input logic [LAGM_POS_W-1:0]   px,
        input logic [LAGM_POS_W-1:0]   py,
        input logic [LAGM_ALPHA_W-1:0] a
    );
        longint proj_d;
        longint mag;
        longint idx;
        longint shaped;
        longint ramp;
        longint gain;
        longint prod;
        proj_d = (longint'(px) * 16 - longint'(center_x_q)) * longint'(slope_x_q)
               + (longint'(py) * 16 - longint'(center_y_q)) * longint'(slope_y_q);
        if (proj_d < -longint'(LAGM_HALF_Q24))
        begin
            gain = longint'(start_gain_q);
        end
        else if (proj_d > longint'(LAGM_HALF_Q24))
        begin
            gain = longint'(end_gain_q);
        end
        else
        begin
            if (shape_q == LAGM_SHAPE_SINE)
            begin
                mag = (proj_d < 0) ? -proj_d : proj_d;
                idx = (mag * LAGM_SINE_DEPTH + LAGM_ROUND_IDX) >>> 23;
                if (idx > LAGM_SINE_DEPTH)
                begin
                    idx = LAGM_SINE_DEPTH;
                end
                shaped = sine_q16[idx] * 128;
                proj_d = (proj_d < 0) ? -shaped : shaped;
            end
            ramp = proj_d + LAGM_HALF_Q24;
            gain = (longint'(start_gain_q) * (LAGM_ONE_Q24 - ramp)
                  + longint'(end_gain_q) * ramp) >>> 24;
        end
        prod = (longint'(a) * gain) >>> 16;
        if (prod > 255)
        begin
            return LAGM_ALPHA_MAX;
        end
        return prod[LAGM_ALPHA_W-1:0];
    endfunction

    initial
    begin
        for (int i = 0; i <= LAGM_SINE_DEPTH; i++)
        begin
            sine_q16[i] = quarter_sine_q16(i);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_q   <= '0;
            center_y_q   <= '0;
            slope_x_q    <= '0;
            slope_y_q    <= '0;
            start_gain_q <= LAGM_START_GAIN_RST;
            end_gain_q   <= '0;
            shape_q      <= 1'b0;
            alpha_q.delete();
            outstanding    <= 0;
            mismatch_count <= errors;
            checked        <= seen;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    LAGM_REG_CENTER_X:   center_x_q   <= cfg_data[LAGM_CENTER_W-1:0];
                    LAGM_REG_CENTER_Y:   center_y_q   <= cfg_data[LAGM_CENTER_W-1:0];
                    LAGM_REG_SLOPE_X:    slope_x_q    <= cfg_data[LAGM_SLOPE_W-1:0];
                    LAGM_REG_SLOPE_Y:    slope_y_q    <= cfg_data[LAGM_SLOPE_W-1:0];
                    LAGM_REG_START_GAIN: start_gain_q <= cfg_data[LAGM_GAIN_W-1:0];
                    LAGM_REG_END_GAIN:   end_gain_q   <= cfg_data[LAGM_GAIN_W-1:0];
                    LAGM_REG_SHAPE_MODE: shape_q      <= cfg_data[0];
                    default:             ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (alpha_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: alpha_out %0d arrived with no pixel pending",
                             $time, alpha_out);
                end
                else
                begin
                    head_item = alpha_q.pop_front();
                    seen++;
                    if (alpha_out !== head_item.alpha_exp)
                    begin
                        errors++;
                        $display("%0t: pixel (%0d,%0d) alpha %0d: expected alpha_out %0d, got %0d",
                                 $time, head_item.px, head_item.py, head_item.alpha_src,
                                 head_item.alpha_exp, alpha_out);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                fresh_item.px        = pixel_x;
                fresh_item.py        = pixel_y;
                fresh_item.alpha_src = alpha_in;
                fresh_item.alpha_exp = gradient_alpha(pixel_x, pixel_y, alpha_in);
                alpha_q.push_back(fresh_item);
            end
            outstanding    <= alpha_q.size();
            mismatch_count <= errors;
            checked        <= seen;
        end
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Gradient mask testbench
// Drives pixels into the gradient mask under several register settings,
// linear and sine ramps, and four idle patterns on both channels, including
// a long output hold-off that backs the pipeline up into its input. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import lagm_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 5;
    localparam int PIPE_LATENCY     = 9;
    localparam int SETTLE_CYCLES    = 3 * PIPE_LATENCY;
    localparam int HOLD_CYCLES      = 400;
    localparam int RANDOM_PHASES    = 12;
    localparam int PIXELS_PER_PHASE = 110;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int FRAME_MAX        = (1 << LAGM_POS_W) - 1;
    localparam logic [LAGM_CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [LAGM_CFG_IDX_W-1:0]  cfg_index = '0;
    logic [LAGM_CFG_DATA_W-1:0] cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [LAGM_POS_W-1:0]      pixel_x = '0;
    logic [LAGM_POS_W-1:0]      pixel_y = '0;
    logic [LAGM_ALPHA_W-1:0]    alpha_in = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [LAGM_ALPHA_W-1:0]    alpha_out;

    int mismatches;
    int outstanding;
    int checked;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_served = 0;
    int hold_left = 0;
    int pixels_sent = 0;
    int settings_applied = 0;
    int cur_cx = 0;
    int cur_cy = 0;

    linear_alpha_gradient_mask u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .alpha_in  (alpha_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .alpha_out (alpha_out)
    );

    lagm_alpha_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .alpha_in       (alpha_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .alpha_out      (alpha_out),
        .mismatch_count (mismatches),
        .outstanding    (outstanding),
        .checked        (checked)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_served != hold_request)
        begin
            hold_served <= hold_request;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= (int'($urandom_range(0, 99)) >= stall_pct);
        end
    end

    task automatic write_reg(input logic [LAGM_CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= LAGM_CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input int cx, input int cy, input int sx, input int sy,
                                 input int sg, input int eg, input int mode);
        write_reg(LAGM_REG_CENTER_X, cx);
        write_reg(LAGM_REG_CENTER_Y, cy);
        write_reg(LAGM_REG_SLOPE_X, sx);
        write_reg(LAGM_REG_SLOPE_Y, sy);
        write_reg(LAGM_REG_START_GAIN, sg);
        write_reg(LAGM_REG_END_GAIN, eg);
        write_reg(LAGM_REG_SHAPE_MODE, mode);
        cur_cx = cx;
        cur_cy = cy;
        settings_applied++;
    endtask

    task automatic send_pixel(input logic [LAGM_POS_W-1:0] px,
                              input logic [LAGM_POS_W-1:0] py,
                              input logic [LAGM_ALPHA_W-1:0] a);
        while (int'($urandom_range(0, 99)) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x  <= px;
        pixel_y  <= py;
        alpha_in <= a;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [LAGM_POS_W-1:0] near_coord(input int center16, input int spread);
        int coord;
        coord = center16 / 16 + int'($urandom_range(0, 2 * spread)) - spread;
        if (coord < 0)
        begin
            coord = 0;
        end
        else if (coord > FRAME_MAX)
        begin
            coord = FRAME_MAX;
        end
        return coord[LAGM_POS_W-1:0];
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 65536;
            2:       return int'($urandom_range(65537, 131071));
            default: return int'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic int pick_slope();
        if ($urandom_range(0, 3) == 0)
        begin
            return int'($urandom_range(0, 16777215)) - 8388608;
        end
        return int'($urandom_range(0, 4096)) - 2048;
    endfunction

    function automatic int pick_center();
        if ($urandom_range(0, 3) == 0)
        begin
            return int'($urandom_range(0, 131071)) - 65536;
        end
        return int'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [LAGM_POS_W-1:0]   px;
        logic [LAGM_POS_W-1:0]   py;
        logic [LAGM_ALPHA_W-1:0] a;
        int spread;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: zero slopes put every pixel at the middle of the band.
        send_pixel(12'd0, 12'd0, 8'd0);
        send_pixel(12'd4095, 12'd4095, 8'd255);
        send_pixel(12'd1234, 12'd567, 8'd128);
        wait_idle();

        // Diagonal ramp across the frame: exact band edges and points past them.
        apply_setting(32768, 32768, 256, 256, 65536, 0, 0);
        send_pixel(12'd0, 12'd0, 8'd200);
        send_pixel(12'd1024, 12'd1024, 8'd255);
        send_pixel(12'd2048, 12'd2048, 8'd255);
        send_pixel(12'd3072, 12'd3072, 8'd255);
        send_pixel(12'd3072, 12'd3073, 8'd255);
        send_pixel(12'd4095, 12'd4095, 8'd255);
        send_pixel(12'd1500, 12'd2600, 8'd77);
        wait_idle();

        write_reg(LAGM_REG_SHAPE_MODE, 1);
        send_pixel(12'd2048, 12'd2048, 8'd255);
        send_pixel(12'd2560, 12'd2560, 8'd255);
        send_pixel(12'd1536, 12'd1536, 8'd255);
        send_pixel(12'd1024, 12'd1024, 8'd255);
        send_pixel(12'd3072, 12'd3072, 8'd255);
        send_pixel(12'd2600, 12'd2100, 8'd99);
        wait_idle();

        // Gains above one saturate the product.
        write_reg(LAGM_REG_START_GAIN, 131071);
        write_reg(LAGM_REG_END_GAIN, 65536);
        send_pixel(12'd0, 12'd0, 8'd255);
        send_pixel(12'd0, 12'd0, 8'd1);
        send_pixel(12'd4095, 12'd4095, 8'd255);
        send_pixel(12'd2300, 12'd2048, 8'd200);
        wait_idle();

        // A write to an unmapped index must leave every register alone.
        write_reg(REG_UNMAPPED, 24'hFFFFFF);
        send_pixel(12'd2300, 12'd2048, 8'd200);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                apply_setting(-65536, 65535, 8388607, -8388608, 0, 65536, 0);
            end
            else if (phase == 1)
            begin
                apply_setting(65535, -65536, -8388608, 8388607, 131071, 0, 1);
            end
            else
            begin
                apply_setting(pick_center(), pick_center(), pick_slope(), pick_slope(),
                              pick_gain(), pick_gain(), int'($urandom_range(0, 1)));
            end
            case (phase % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 61;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 61;
                end
                default:
                begin
                    idle_pct = 22;
                    stall_pct <= 22;
                end
            endcase
            if (phase == 4 || phase == 8)
            begin
                hold_request <= hold_request + 1;
            end
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
            begin
                spread = int'($urandom_range(1, 256));
                if ($urandom_range(0, 9) < 6)
                begin
                    px = near_coord(cur_cx, spread);
                    py = near_coord(cur_cy, spread);
                end
                else
                begin
                    px = LAGM_POS_W'($urandom_range(0, FRAME_MAX));
                    py = LAGM_POS_W'($urandom_range(0, FRAME_MAX));
                end
                case ($urandom_range(0, 9))
                    0:       a = '0;
                    1:       a = LAGM_ALPHA_MAX;
                    default: a = LAGM_ALPHA_W'($urandom_range(0, 255));
                endcase
                send_pixel(px, py, a);
            end
            wait_idle();
        end

        $display("Covered %0d pixels over %0d register settings, linear and sine ramps,",
                 pixels_sent, settings_applied);
        $display("four idle patterns and %0d long output hold-offs; %0d results in %0d cycles.",
                 hold_request, checked, cycle_count);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
